// ===== sv/pts_pkg.sv =====
// Shared types, codes and constants of the periodic task scheduler.
package pts_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int ID_BITS_DEF = 8;
	localparam int MAX_OUT     = 16;

	localparam logic [31:0] REBASE_LIMIT   = 32'h7ff0_0000;
	localparam logic [31:0] CLEARED_DUE    = 32'hffff_ffff;
	localparam logic [31:0] CLEARED_PERIOD = 32'd10000;
	localparam logic [31:0] RESET_TIME     = 32'd1;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_POLL   = 3'd3;
	localparam logic [2:0] OP_SET    = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  task_id;
		logic [31:0] period;
		logic [31:0] new_time;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  due_task;
		logic        fired;
		logic [31:0] clock_now;
		logic        table_full;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_FILL,
		ST_FIN
	} state_t;

endpackage

// ===== sv/pts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/periodic_task_scheduler.sv =====
// Periodic task scheduler: slot table in RAM walked by a small sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  cmd     | in        | cmd_valid/cmd_stall  | operation, task_id, period, time
//  res     | out       | res_valid/res_stall  | due_task, fired, clock, full, last
//
// Tick without rebase, remove/add with id zero and unknown codes skip the slot walk.
// Poll, remove, add and rebase walk the slots, each slot as a RAM read and then,
// where needed, an update through the write port; an add that fills an empty
// slot ends in a fill state. Reset is asynchronous; per-slot valid bits stand in
// for the table's reset contents, so no clearing pass is needed. A stalled
// result holds the poll scan until the output register frees.
module periodic_task_scheduler #(
	parameter int SLOTS   = pts_pkg::SLOTS_DEF,
	parameter int ID_BITS = pts_pkg::ID_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  pts_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output pts_pkg::res_t res
);

	import pts_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENT_W = ID_BITS + 64;
	localparam int CNT_W = $clog2(MAX_OUT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [ENT_W-1:0] RESET_ENTRY = {{ID_BITS{1'b0}}, RESET_TIME, RESET_TIME};

	state_t state_q, state_n;
	logic [IDX_W-1:0] idx_q, idx_n;
	logic [31:0] clock_q, clock_n;
	logic rebase_q, rebase_n;
	logic found_q, found_n;
	logic empty_hit_q, empty_hit_n;
	logic [IDX_W-1:0] empty_idx_q, empty_idx_n;
	logic pend_vld_q, pend_vld_n;
	logic [ID_BITS-1:0] pend_id_q, pend_id_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic out_valid_q, out_valid_n;
	res_t out_q, out_n;
	logic [SLOTS-1:0] vld_q, vld_n;

	logic [2:0] op_q, op_n;
	logic [ID_BITS-1:0] id_q, id_n;
	logic [31:0] per_q, per_n;
	logic [31:0] tgt_q, tgt_n;

	logic ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENT_W-1:0] ram_wdata, ram_rdata, ent;
	logic [ID_BITS-1:0] ent_owner, id_in;
	logic [31:0] ent_per, ent_due, wait_t, tick_next;
	logic [15:0] tid_ext, pid_ext;
	logic out_free, accept, slot_match, fire;

	pts_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign out_free  = !out_valid_q || !res_stall;

	assign tid_ext = 16'(cmd.task_id);
	assign id_in   = tid_ext[ID_BITS-1:0];
	assign pid_ext = 16'(pend_id_q);

	assign ent       = vld_q[idx_q] ? ram_rdata : RESET_ENTRY;
	assign ent_owner = ent[ENT_W-1:64];
	assign ent_per   = ent[63:32];
	assign ent_due   = ent[31:0];
	assign wait_t    = ent_due - clock_q;
	assign tick_next = clock_q + 32'd1;
	assign slot_match = (ent_owner == id_q);
	assign fire = (ent_owner != '0) && (clock_q >= ent_due);

	always_comb begin
		state_n     = state_q;
		idx_n       = idx_q;
		clock_n     = clock_q;
		rebase_n    = rebase_q;
		found_n     = found_q;
		empty_hit_n = empty_hit_q;
		empty_idx_n = empty_idx_q;
		pend_vld_n  = pend_vld_q;
		pend_id_n   = pend_id_q;
		cnt_n       = cnt_q;
		out_valid_n = out_valid_q && res_stall;
		out_n       = out_q;
		vld_n       = vld_q;
		op_n        = op_q;
		id_n        = id_q;
		per_n       = per_q;
		tgt_n       = tgt_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_waddr   = idx_q;
		ram_wdata   = ent;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_n        = cmd.operation;
					id_n        = id_in;
					per_n       = cmd.period;
					tgt_n       = 32'd0;
					rebase_n    = 1'b0;
					found_n     = 1'b0;
					empty_hit_n = 1'b0;
					pend_vld_n  = 1'b0;
					cnt_n       = '0;
					idx_n       = '0;
					state_n     = ST_FIN;
					unique case (cmd.operation)
						OP_TICK: begin
							clock_n  = tick_next;
							rebase_n = (tick_next >= REBASE_LIMIT);
						end
						OP_SET: begin
							tgt_n    = cmd.new_time;
							rebase_n = (cmd.new_time != clock_q);
						end
						OP_ADD, OP_REMOVE: begin
							if (id_in != '0) begin
								state_n = ST_RD;
							end
						end
						OP_POLL: state_n = ST_RD;
						default: state_n = ST_FIN;
					endcase
					if (rebase_n) begin
						state_n = ST_RD;
					end
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_n = ST_EV;
			end
			ST_EV: begin
				logic advance;
				logic stop;
				advance = 1'b1;
				stop    = 1'b0;
				if (rebase_q) begin
					ram_we    = 1'b1;
					ram_wdata = {ent_owner, ent_per, wait_t[31] ? tgt_q : wait_t + tgt_q};
				end else begin
					unique case (op_q)
						OP_ADD: begin
							if (slot_match) begin
								found_n = 1'b1;
								if (ent_per != per_q) begin
									ram_we    = 1'b1;
									ram_wdata = {ent_owner, per_q, clock_q + per_q};
								end
							end
							if (ent_owner == '0 && !empty_hit_q) begin
								empty_hit_n = 1'b1;
								empty_idx_n = idx_q;
							end
						end
						OP_REMOVE: begin
							if (slot_match) begin
								ram_we    = 1'b1;
								ram_wdata = {{ID_BITS{1'b0}}, CLEARED_PERIOD, CLEARED_DUE};
							end
						end
						OP_POLL: begin
							if (fire) begin
								if (pend_vld_q && !out_free) begin
									// hold until the earlier transaction leaves
									advance = 1'b0;
								end else begin
									if (pend_vld_q) begin
										out_valid_n = 1'b1;
										out_n = '{due_task: pid_ext[7:0], fired: 1'b1,
											clock_now: clock_q, table_full: 1'b0, last: 1'b0};
									end
									ram_we     = 1'b1;
									ram_wdata  = {ent_owner, ent_per, ent_per + clock_q};
									pend_vld_n = 1'b1;
									pend_id_n  = ent_owner;
									cnt_n      = cnt_q + CNT_W'(1);
									stop       = (cnt_n == CNT_W'(MAX_OUT));
								end
							end
						end
						default: advance = 1'b1;
					endcase
				end
				if (ram_we) begin
					vld_n[idx_q] = 1'b1;
				end
				if (advance) begin
					if (stop) begin
						state_n = ST_FIN;
					end else if (idx_q == LAST_IDX) begin
						if (!rebase_q && op_q == OP_ADD && !found_n && empty_hit_n) begin
							state_n = ST_FILL;
						end else begin
							state_n = ST_FIN;
						end
					end else begin
						idx_n   = idx_q + IDX_W'(1);
						state_n = ST_RD;
					end
				end
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = empty_idx_q;
				ram_wdata = {id_q, per_q, clock_q + per_q};
				vld_n[empty_idx_q] = 1'b1;
				state_n   = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					clock_n     = rebase_q ? tgt_q : clock_q;
					out_valid_n = 1'b1;
					if (op_q == OP_POLL && pend_vld_q) begin
						out_n = '{due_task: pid_ext[7:0], fired: 1'b1,
							clock_now: clock_q, table_full: 1'b0, last: 1'b1};
					end else begin
						out_n = '{due_task: 8'd0, fired: 1'b0, clock_now: clock_n,
							table_full: (op_q == OP_ADD) && (id_q != '0) && !found_q
								&& !empty_hit_q,
							last: 1'b1};
					end
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clock_q     <= '0;
			rebase_q    <= 1'b0;
			found_q     <= 1'b0;
			empty_hit_q <= 1'b0;
			pend_vld_q  <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			state_q     <= state_n;
			clock_q     <= clock_n;
			rebase_q    <= rebase_n;
			found_q     <= found_n;
			empty_hit_q <= empty_hit_n;
			pend_vld_q  <= pend_vld_n;
			cnt_q       <= cnt_n;
			idx_q       <= idx_n;
			out_valid_q <= out_valid_n;
			vld_q       <= vld_n;
		end
	end

	always_ff @(posedge clk) begin
		op_q        <= op_n;
		id_q        <= id_n;
		per_q       <= per_n;
		tgt_q       <= tgt_n;
		empty_idx_q <= empty_idx_n;
		pend_id_q   <= pend_id_n;
		out_q       <= out_n;
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("scheduler idle right after taking a transaction");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != ST_IDLE)
		else $error("slot table written while idle");

	a_fired_has_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.fired |-> res.due_task != 8'd0)
		else $error("fired result without a task id");

	a_full_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.table_full |-> res.last && !res.fired)
		else $error("table full flagged on a non-final or fired result");

endmodule

// ===== dv/periodic_task_scheduler_tb.sv =====
// Self-checking testbench for the periodic task scheduler: directed cases, random traffic, back-pressure.
module periodic_task_scheduler_tb;
	import pts_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF    = 400;
	localparam int DRAIN       = 100;
	localparam int MAX_REPORTS = 10;

	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	periodic_task_scheduler #(
		.SLOTS(SLOTS_DEF),
		.ID_BITS(ID_BITS_DEF)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the slot table and the tick clock
	logic [7:0]  owner_m  [SLOTS_DEF];
	logic [31:0] period_m [SLOTS_DEF];
	logic [31:0] due_m    [SLOTS_DEF];
	logic [31:0] clock_m;

	res_t expected_res[$];
	int   mismatches = 0;
	bit   tx_idle = 1'b0;
	bit   rx_idle = 1'b0;
	int   rx_hold = 0;
	int   quiet_cycles = 0;

	function automatic void clear_table();
		for (int i = 0; i < SLOTS_DEF; i++) begin
			owner_m[i]  = '0;
			period_m[i] = 32'd1;
			due_m[i]    = 32'd1;
		end
		clock_m = '0;
	endfunction

	// Keep each slot's remaining wait, clamped at zero, across a clock jump
	function automatic void shift_clock(logic [31:0] target);
		logic [31:0] remaining;
		if (target == clock_m)
			return;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			remaining = due_m[i] - clock_m;
			if (remaining[31])
				remaining = '0;
			due_m[i] = remaining + target;
		end
		clock_m = target;
	endfunction

	function automatic res_t make_res(logic [7:0] id, logic fired, logic full, logic fin);
		res_t r;
		r.due_task   = id;
		r.fired      = fired;
		r.clock_now  = clock_m;
		r.table_full = full;
		r.last       = fin;
		return r;
	endfunction

	function automatic void schedule_step(cmd_t c);
		logic [7:0] id;
		logic [7:0] fired_ids[$];
		logic       full;
		bit         found;
		bit         placed;
		id     = c.task_id;
		full   = 1'b0;
		found  = 1'b0;
		placed = 1'b0;
		case (c.operation)
			OP_TICK: begin
				clock_m = clock_m + 32'd1;
				if (clock_m >= REBASE_LIMIT)
					shift_clock('0);
			end
			OP_ADD: begin
				if (id != '0) begin
					for (int i = 0; i < SLOTS_DEF; i++) begin
						if (owner_m[i] == id) begin
							if (period_m[i] != c.period) begin
								period_m[i] = c.period;
								due_m[i]    = clock_m + c.period;
							end
							found = 1'b1;
						end
					end
					if (!found) begin
						for (int i = 0; i < SLOTS_DEF && !placed; i++) begin
							if (owner_m[i] == '0) begin
								owner_m[i]  = id;
								period_m[i] = c.period;
								due_m[i]    = clock_m + c.period;
								placed      = 1'b1;
							end
						end
						if (!placed)
							full = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				if (id != '0) begin
					for (int i = 0; i < SLOTS_DEF; i++) begin
						if (owner_m[i] == id) begin
							owner_m[i]  = '0;
							period_m[i] = CLEARED_PERIOD;
							due_m[i]    = CLEARED_DUE;
						end
					end
				end
			end
			OP_POLL: begin
				for (int i = 0; i < SLOTS_DEF && fired_ids.size() < MAX_OUT; i++) begin
					if (owner_m[i] != '0 && clock_m >= due_m[i]) begin
						due_m[i] = period_m[i] + clock_m;
						fired_ids.push_back(owner_m[i]);
					end
				end
			end
			OP_SET: shift_clock(c.new_time);
			default: ;
		endcase
		if (fired_ids.size() > 0) begin
			for (int k = 0; k < fired_ids.size(); k++)
				expected_res.push_back(make_res(fired_ids[k], 1'b1, 1'b0,
					k == fired_ids.size() - 1));
		end else begin
			expected_res.push_back(make_res('0, 1'b0, full, 1'b1));
		end
	endfunction

	function automatic cmd_t make_cmd(logic [2:0] op, logic [7:0] id, logic [31:0] per,
			logic [31:0] t);
		cmd_t c;
		c.operation = op;
		c.task_id   = id;
		c.period    = per;
		c.new_time  = t;
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			c.operation = OP_TICK;
		else if (pick < 50)
			c.operation = OP_ADD;
		else if (pick < 60)
			c.operation = OP_REMOVE;
		else if (pick < 85)
			c.operation = OP_POLL;
		else if (pick < 95)
			c.operation = OP_SET;
		else
			c.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

		// Mostly a small pool of ids, so that adds match and the table fills
		pick = $urandom_range(0, 99);
		if (pick < 5)
			c.task_id = '0;
		else if (pick < 80)
			c.task_id = 8'($urandom_range(1, 24));
		else
			c.task_id = 8'($urandom_range(0, 255));

		pick = $urandom_range(0, 99);
		if (pick < 70)
			c.period = $urandom_range(0, 16);
		else if (pick < 90)
			c.period = $urandom_range(0, 1000);
		else
			c.period = $urandom;

		pick = $urandom_range(0, 99);
		if (pick < 40)
			c.new_time = clock_m + $urandom_range(0, 40) - 20;
		else if (pick < 55)
			c.new_time = REBASE_LIMIT - $urandom_range(1, 8);
		else if (pick < 65)
			c.new_time = 32'hffff_ffff - $urandom_range(0, 4);
		else if (pick < 75)
			c.new_time = clock_m;
		else
			c.new_time = $urandom;
		return c;
	endfunction

	// Entered and left at a falling edge
	task automatic send_cmd(cmd_t c);
		int gap;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		schedule_step(c);
		@(negedge clk);
	endtask

	task automatic send_random(int count);
		for (int n = 0; n < count; n++)
			send_cmd(rand_cmd());
	endtask

	task automatic note_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s: got task %02h fired %0b clock %08h full %0b last %0b",
				what, res.due_task, res.fired, res.clock_now, res.table_full, res.last);
	endtask

	// Receiver: random stall per transaction, plus an occasional long hold-off
	initial begin
		int gap;
		res_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold > 0) begin
				res_stall <= 1'b1;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			gap = rx_idle ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid && rx_hold == 0)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_res.size() == 0) begin
				note_mismatch("unexpected result");
			end else begin
				want = expected_res.pop_front();
				if (res !== want) begin
					if (mismatches < MAX_REPORTS)
						$display("expected task %02h fired %0b clock %08h full %0b last %0b",
							want.due_task, want.fired, want.clock_now, want.table_full,
							want.last);
					note_mismatch("result mismatch");
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("periodic_task_scheduler_tb failed");
			$finish;
		end
	end

	task automatic test_empty_table();
		send_cmd(make_cmd(OP_POLL, 8'h00, 32'h0, 32'h0));
	endtask

	task automatic test_id_zero();
		send_cmd(make_cmd(OP_ADD, 8'h00, 32'd5, 32'h0));
		send_cmd(make_cmd(OP_REMOVE, 8'h00, 32'd5, 32'h0));
	endtask

	task automatic test_unknown_op();
		send_cmd(make_cmd(OP_UNUSED_HI, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
	endtask

	// Fill every slot with a task due at once, overflow it, fire all in one poll
	task automatic test_table_full();
		send_cmd(make_cmd(OP_ADD, 8'hff, 32'd0, 32'h0));
		send_cmd(make_cmd(OP_ADD, 8'hff, 32'd0, 32'h0));
		for (int i = 1; i < SLOTS_DEF; i++)
			send_cmd(make_cmd(OP_ADD, i[7:0], 32'd0, 32'h0));
		send_cmd(make_cmd(OP_ADD, 8'h80, 32'd3, 32'h0));
		send_cmd(make_cmd(OP_POLL, 8'h00, 32'h0, 32'h0));
		send_cmd(make_cmd(OP_REMOVE, 8'hff, 32'h0, 32'h0));
	endtask

	task automatic test_rebase();
		send_cmd(make_cmd(OP_SET, 8'h00, 32'h0, REBASE_LIMIT - 32'd1));
		send_cmd(make_cmd(OP_TICK, 8'h00, 32'h0, 32'h0));
		send_cmd(make_cmd(OP_SET, 8'h00, 32'h0, 32'hffff_ffff));
		send_cmd(make_cmd(OP_TICK, 8'h00, 32'h0, 32'h0));
	endtask

	task automatic test_random_traffic();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_random(40);
		rx_idle = 1'b0;
		send_random(30);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		send_random(30);
		rx_idle = 1'b0;
		send_random(30);
	endtask

	// Hold the result side off while commands keep coming, so the input stalls
	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = HOLD_OFF;
		for (int i = 1; i <= 4; i++)
			send_cmd(make_cmd(OP_ADD, i[7:0], 32'd0, 32'h0));
		for (int n = 0; n < 20; n++) begin
			if (n % 2 == 0)
				send_cmd(make_cmd(OP_POLL, 8'h00, 32'h0, 32'h0));
			else
				send_cmd(rand_cmd());
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_random(20);
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		clear_table();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_id_zero();
		test_unknown_op();
		test_table_full();
		test_rebase();
		test_random_traffic();
		test_backpressure();

		cmd_valid <= 1'b0;
		while (expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && expected_res.size() == 0)
			$display("periodic_task_scheduler_tb passed");
		else
			$display("periodic_task_scheduler_tb failed");
		$finish;
	end

endmodule
